FILE: rtl/core/lspe_pkg.sv
package lspe_pkg;

    localparam int NUM_CH    = 8;
    localparam int LEVEL_W   = 8;
    localparam int CH_W      = 3;
    localparam int ERR_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = NUM_CH * LEVEL_W;

    // channel map of the sensor
    localparam logic [CH_W-1:0] CH_INNER_LEFT  = 3'd3;
    localparam logic [CH_W-1:0] CH_INNER_RIGHT = 3'd4;
    localparam logic [CH_W-1:0] CH_LAST_LOW    = 3'd2;

    typedef logic [LEVEL_W-1:0]              t_level;
    typedef logic [NUM_CH-1:0][LEVEL_W-1:0]  t_levels;
    typedef logic signed [ERR_W-1:0]         t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIDE_PEAK  = 1'b0,
        CFG_CENTRE_THR = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_INNER,
        MODE_OUTER
    } t_mode;

    // operands handed from channel selection to the error arithmetic
    typedef struct packed {
        t_mode  mode;
        t_level left;
        t_level centre;
        t_level right;
        t_level peak;
        t_level thr;
    } t_operands;

endpackage

FILE: rtl/core/lspe_select.sv
module lspe_select (
    input  logic [lspe_pkg::NUM_CH-1:0] i_line_bits,
    input  lspe_pkg::t_levels           i_levels,
    input  lspe_pkg::t_levels           i_peaks,
    input  lspe_pkg::t_levels           i_thrs,
    output lspe_pkg::t_operands         o_ops
);
    import lspe_pkg::*;

    always_comb begin
        logic            found;
        logic [CH_W-1:0] pos;
        logic [CH_W-1:0] c;
        t_level          pl;
        t_level          pr;

        found = 1'b0;
        pos   = '0;
        // low side: last dark channel wins
        for (int i = 0; i <= int'(CH_LAST_LOW); i++) begin
            if (!i_line_bits[i]) begin
                found = 1'b1;
                pos   = CH_W'(i);
            end
        end
        // high side overrides: first dark channel from 3 upwards
        for (int i = NUM_CH - 1; i >= int'(CH_INNER_LEFT); i--) begin
            if (!i_line_bits[i]) begin
                found = 1'b1;
                pos   = CH_W'(i);
            end
        end

        c = (pos <= CH_LAST_LOW) ? pos + 3'd1 : pos - 3'd1;
        pl = i_peaks[c - 3'd1];
        pr = i_peaks[c + 3'd1];

        o_ops.peak   = (pl > pr) ? pl : pr;
        o_ops.thr    = i_thrs[c];
        o_ops.centre = i_levels[c];
        if (!found) begin
            o_ops.mode  = MODE_NONE;
            o_ops.left  = i_levels[c - 3'd1];
            o_ops.right = i_levels[c + 3'd1];
        end else if (pos == CH_INNER_LEFT || pos == CH_INNER_RIGHT) begin
            o_ops.mode  = MODE_INNER;
            o_ops.left  = i_levels[CH_INNER_LEFT];
            o_ops.right = i_levels[CH_INNER_RIGHT];
        end else begin
            o_ops.mode  = MODE_OUTER;
            o_ops.left  = i_levels[c - 3'd1];
            o_ops.right = i_levels[c + 3'd1];
        end
    end

endmodule

FILE: rtl/core/lspe_error.sv
module lspe_error (
    input  lspe_pkg::t_operands i_ops,
    output lspe_pkg::t_err      o_err
);
    import lspe_pkg::*;

    logic signed [ERR_W:0] l;
    logic signed [ERR_W:0] r;
    logic signed [ERR_W:0] p2;
    logic signed [ERR_W:0] err;

    assign l  = $signed({3'b000, i_ops.left});
    assign r  = $signed({3'b000, i_ops.right});
    assign p2 = $signed({2'b00, i_ops.peak, 1'b0});

    always_comb begin
        case (i_ops.mode)
            MODE_INNER: err = l - r;
            MODE_OUTER: begin
                if (i_ops.centre > i_ops.thr) begin
                    err = l - r;
                end else if (l > r) begin
                    err = p2 - l - r;   // fold about the brighter side peak
                end else if (l < r) begin
                    err = l + r - p2;
                end else begin
                    err = '0;           // even sides, dim centre
                end
            end
            default: err = '0;
        endcase
    end

    assign o_err = err[ERR_W-1:0];

endmodule

FILE: rtl/core/line_sensor_position_error_core.sv
// Channel   Direction  Signals
// request   in         start, i_line_bits, i_level_0 .. i_level_7 (busy is out)
// result    out        o_done, o_steer_error
// config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// One request per cycle; the result strobes o_done once an accepted request has
// passed the input register and then the result register around the selection
// and error logic. busy is never raised.
// Synchronous active-low reset clears the pipeline valids and both config words.
// The receiver cannot stall: each result is shown for exactly one cycle.
module line_sensor_position_error_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lspe_pkg::NUM_CH-1:0]    i_line_bits,
    input  lspe_pkg::t_level               i_level_0,
    input  lspe_pkg::t_level               i_level_1,
    input  lspe_pkg::t_level               i_level_2,
    input  lspe_pkg::t_level               i_level_3,
    input  lspe_pkg::t_level               i_level_4,
    input  lspe_pkg::t_level               i_level_5,
    input  lspe_pkg::t_level               i_level_6,
    input  lspe_pkg::t_level               i_level_7,
    output logic                           o_done,
    output lspe_pkg::t_err                 o_steer_error,
    input  logic                           i_cfg_we,
    input  logic [lspe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lspe_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import lspe_pkg::*;

    logic               accept;
    t_levels            r_peaks;
    t_levels            r_thrs;
    logic               r_in_valid;
    logic [NUM_CH-1:0]  r_bits;
    t_levels            r_levels;
    logic               r_done;
    t_err               r_err;
    t_operands          ops;
    t_err               n_err;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peaks <= '0;
            r_thrs  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIDE_PEAK:  r_peaks <= i_cfg_wdata;
                CFG_CENTRE_THR: r_thrs  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= accept;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bits   <= i_line_bits;
            r_levels <= {i_level_7, i_level_6, i_level_5, i_level_4,
                         i_level_3, i_level_2, i_level_1, i_level_0};
        end
        r_err <= n_err;
    end

    lspe_select u_select (
        .i_line_bits (r_bits),
        .i_levels    (r_levels),
        .i_peaks     (r_peaks),
        .i_thrs      (r_thrs),
        .o_ops       (ops)
    );

    lspe_error u_error (
        .i_ops (ops),
        .o_err (n_err)
    );

    assign o_done        = r_done;
    assign o_steer_error = r_err;

`ifndef NO_ASSERTIONS
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("accepted request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> !o_done)
        else $error("result strobe without a request");

    a_no_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_line_bits == '1) |=> ##1 (o_steer_error == '0))
        else $error("no line seen but error is non-zero");

    a_inner_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && ops.mode == MODE_INNER) |=>
        (o_steer_error == t_err'($signed({2'b00, $past(r_levels[CH_INNER_LEFT])})
                                - $signed({2'b00, $past(r_levels[CH_INNER_RIGHT])}))))
        else $error("inner position error mismatch");
`endif

endmodule
